@@ src/csort_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csort_pkg;

    // payload widths
    localparam int CHAR_W   = 8;
    localparam int RANK_W   = 10;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

endpackage

`default_nettype wire

@@ src/csort_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface csort_req_if;
    import csort_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output req_type, output char_code, output is_last,
                    output rank, input ready);
    modport sink   (input valid, input req_type, input char_code, input is_last,
                    input rank, output ready);
endinterface

`default_nettype wire

@@ src/csort_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface csort_rsp_if;
    import csort_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output position, output status, input ready);
    modport sink   (input valid, input position, input status, output ready);
endinterface

`default_nettype wire

@@ src/csort_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port ram, one write and one registered read per cycle
module csort_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/cyclic_shift_sorter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Cyclic shift sorter. Characters are loaded one per transaction on req
// (req_type load); the load flagged is_last closes the string and starts a
// prefix-doubling sort of all n cyclic shifts, after which read transactions
// return the start position of the shift at a given rank. Every request gets
// exactly one response on rsp, held until taken. A read that hits the sorted
// order is answered after one ram read. The closing load keeps req blocked
// while sorting: a seed sweep, then a counting pass (clear K buckets, count,
// prefix sum, placement; K = 256 for the byte pass, n afterwards), and for
// each of the ceil(log2 n) doubling passes a shift sweep, a counting pass, a
// renumbering sweep and a copy sweep. The sweeps are paced by the single read
// port of each ram, mostly the class store, which is read once per cycle.
module cyclic_shift_sorter #(
    parameter int MAX_LEN = 1024
) (
    input wire logic   clk,
    input wire logic   rst_n,
    csort_req_if.sink  req,
    csort_rsp_if.source rsp
);
    import csort_pkg::*;

    localparam int AW   = $clog2(MAX_LEN);          // position width
    localparam int LW   = AW + 1;                   // length width
    localparam int HW   = LW + 1;                   // doubling step width
    localparam int CW   = (AW > CHAR_W) ? AW : CHAR_W;  // class width
    localparam int NB   = (MAX_LEN > 256) ? MAX_LEN : 256; // bucket count
    localparam int IW   = CW + 1;                   // sweep counter width
    localparam int CMPW = (LW > RANK_W) ? LW : RANK_W;

    typedef enum logic [4:0] {
        S_IDLE, S_RDOUT,
        S_INIT_RD, S_INIT_WR,
        S_CLR,
        S_CNT_A, S_CNT_B, S_CNT_C, S_CNT_D,
        S_SUM_RD, S_SUM_WR,
        S_DST_A, S_DST_B, S_DST_C, S_DST_D,
        S_HCHK,
        S_SHF_RD, S_SHF_WR,
        S_REN_0, S_REN_1, S_REN_A, S_REN_B, S_REN_C, S_REN_D, S_REN_E, S_REN_F,
        S_CPY_RD, S_CPY_WR
    } state_t;

    // control and sweep registers
    state_t              state_reg;
    logic [LW-1:0]       len_reg;
    logic                sorted_reg;
    logic [LW-1:0]       n_reg;
    logic [HW-1:0]       h_reg;
    logic [IW-1:0]       idx_reg;
    logic                first_reg;     // byte pass, buckets span the alphabet
    logic [AW-1:0]       pos_reg;
    logic [CW-1:0]       cls_reg;
    logic [LW-1:0]       run_reg;       // running prefix sum of bucket counts
    logic [CW-1:0]       crun_reg;      // running class number while renumbering
    logic [AW-1:0]       prev_reg;
    logic [AW-1:0]       cur_reg;
    logic [CW-1:0]       x_reg;
    logic                eq_reg;

    // response register
    logic                out_vld_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic [STATUS_W-1:0] out_st_reg;

    // ram ports
    logic              txt_we;
    logic [AW-1:0]     txt_waddr, txt_raddr;
    logic [CHAR_W-1:0] txt_wdata, txt_rdata;
    logic              oa_we, ob_we;
    logic [AW-1:0]     oa_waddr, oa_raddr, oa_wdata, oa_rdata;
    logic [AW-1:0]     ob_waddr, ob_raddr, ob_wdata, ob_rdata;
    logic              ca_we, cb_we;
    logic [AW-1:0]     ca_waddr, ca_raddr, cb_waddr, cb_raddr;
    logic [CW-1:0]     ca_wdata, ca_rdata, cb_wdata, cb_rdata;
    logic              bk_we;
    logic [CW-1:0]     bk_waddr, bk_raddr;
    logic [LW-1:0]     bk_wdata, bk_rdata;

    // request decode
    logic          accept;
    logic [LW-1:0] len_eff;
    logic          load_ok;
    logic [LW-1:0] len_new;
    logic          read_ok;

    // sweep helpers
    logic [IW-1:0] n_ext;
    logic [IW-1:0] klim;
    logic [IW-1:0] idx_inc;
    logic [IW-1:0] idx_dec;
    logic [LW-1:0] bk_sum;
    logic [LW-1:0] bk_dec;
    logic          same_now;
    logic [CW-1:0] crun_new;

    function automatic logic [AW-1:0] wrap_add(
        input logic [AW-1:0] a,
        input logic [HW-1:0] b,
        input logic [LW-1:0] m
    );
        logic [HW-1:0] s;
        s = HW'(a) + b;
        if (s >= HW'(m))
        begin
            s = s - HW'(m);
        end
        return s[AW-1:0];
    endfunction

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && (!out_vld_reg || rsp.ready);

    // a load after a finished sort starts a fresh string
    assign len_eff = sorted_reg ? '0 : len_reg;
    assign load_ok = len_eff < LW'(MAX_LEN);
    assign len_new = load_ok ? len_eff + LW'(1) : len_eff;
    assign read_ok = sorted_reg && (CMPW'(req.rank) < CMPW'(len_reg));

    assign n_ext    = IW'(n_reg);
    assign klim     = first_reg ? IW'(256) : n_ext;
    assign idx_inc  = idx_reg + IW'(1);
    assign idx_dec  = idx_reg - IW'(1);
    assign bk_sum   = run_reg + bk_rdata;
    assign bk_dec   = bk_rdata - LW'(1);
    assign same_now = eq_reg && (x_reg == ca_rdata);
    assign crun_new = crun_reg + CW'(!same_now);

    assign rsp.valid    = out_vld_reg;
    assign rsp.position = out_pos_reg;
    assign rsp.status   = out_st_reg;

    // ram address and write selection per sweep step
    always_comb
    begin
        txt_we = 1'b0; txt_waddr = len_eff[AW-1:0]; txt_wdata = req.char_code;
        txt_raddr = idx_reg[AW-1:0];
        oa_we = 1'b0; oa_waddr = idx_reg[AW-1:0]; oa_wdata = idx_reg[AW-1:0];
        oa_raddr = idx_reg[AW-1:0];
        ob_we = 1'b0; ob_waddr = bk_dec[AW-1:0]; ob_wdata = pos_reg;
        ob_raddr = idx_reg[AW-1:0];
        ca_we = 1'b0; ca_waddr = idx_reg[AW-1:0]; ca_wdata = CW'(txt_rdata);
        ca_raddr = oa_rdata;
        cb_we = 1'b0; cb_waddr = ob_rdata; cb_wdata = '0;
        cb_raddr = idx_reg[AW-1:0];
        bk_we = 1'b0; bk_waddr = idx_reg[CW-1:0]; bk_wdata = '0;
        bk_raddr = ca_rdata;

        case (state_reg)
            S_IDLE:
            begin
                txt_we   = accept && (req.req_type == REQ_LOAD) && load_ok;
                ob_raddr = AW'(req.rank);
            end
            S_INIT_WR:
            begin
                oa_we = 1'b1;
                ca_we = 1'b1;
            end
            S_CLR:
            begin
                bk_we = 1'b1;
            end
            S_CNT_D:
            begin
                bk_we    = 1'b1;
                bk_waddr = cls_reg;
                bk_wdata = bk_rdata + LW'(1);
            end
            S_SUM_RD:
            begin
                bk_raddr = idx_reg[CW-1:0];
            end
            S_SUM_WR:
            begin
                bk_we    = 1'b1;
                bk_wdata = bk_sum;
            end
            S_DST_A:
            begin
                oa_raddr = idx_dec[AW-1:0];
            end
            S_DST_D:
            begin
                bk_we    = 1'b1;
                bk_waddr = cls_reg;
                bk_wdata = bk_dec;
                ob_we    = 1'b1;
            end
            S_SHF_WR:
            begin
                oa_we    = 1'b1;
                oa_wdata = wrap_add(ob_rdata, HW'(n_reg) - h_reg, n_reg);
            end
            S_REN_0:
            begin
                ob_raddr = '0;
            end
            S_REN_1:
            begin
                cb_we = 1'b1;
            end
            S_REN_B:
            begin
                ca_raddr = ob_rdata;
            end
            S_REN_C:
            begin
                ca_raddr = prev_reg;
            end
            S_REN_D:
            begin
                ca_raddr = wrap_add(cur_reg, h_reg, n_reg);
            end
            S_REN_E:
            begin
                ca_raddr = wrap_add(prev_reg, h_reg, n_reg);
            end
            S_REN_F:
            begin
                cb_we    = 1'b1;
                cb_waddr = cur_reg;
                cb_wdata = crun_new;
            end
            S_CPY_WR:
            begin
                ca_we    = 1'b1;
                ca_wdata = cb_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            sorted_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            // response register
            if (accept)
            begin
                out_vld_reg <= (req.req_type == REQ_LOAD) || !read_ok;
                out_pos_reg <= '0;
                if (req.req_type == REQ_LOAD)
                begin
                    out_st_reg <= load_ok ? ST_OK : ST_OVERFLOW;
                end
                else
                begin
                    out_st_reg <= read_ok ? ST_OK : ST_INVALID;
                end
            end
            else if (state_reg == S_RDOUT)
            begin
                out_vld_reg <= 1'b1;
                out_pos_reg <= POS_W'(ob_rdata);
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.req_type == REQ_LOAD)
                        begin
                            len_reg    <= len_new;
                            sorted_reg <= 1'b0;
                            if (req.is_last)
                            begin
                                n_reg     <= len_new;
                                h_reg     <= HW'(1);
                                idx_reg   <= '0;
                                first_reg <= 1'b1;
                                state_reg <= S_INIT_RD;
                            end
                        end
                        else if (read_ok)
                        begin
                            state_reg <= S_RDOUT;
                        end
                    end
                end
                S_RDOUT:
                begin
                    state_reg <= S_IDLE;
                end
                // seed: identity order, byte classes
                S_INIT_RD:
                begin
                    state_reg <= S_INIT_WR;
                end
                S_INIT_WR:
                begin
                    if (idx_inc == n_ext)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_INIT_RD;
                    end
                end
                // counting pass over order_a into order_b
                S_CLR:
                begin
                    if (idx_inc == klim)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CNT_A;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_CNT_A:
                begin
                    state_reg <= S_CNT_B;
                end
                S_CNT_B:
                begin
                    state_reg <= S_CNT_C;
                end
                S_CNT_C:
                begin
                    cls_reg   <= ca_rdata;
                    state_reg <= S_CNT_D;
                end
                S_CNT_D:
                begin
                    if (idx_inc == n_ext)
                    begin
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        state_reg <= S_SUM_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_CNT_A;
                    end
                end
                S_SUM_RD:
                begin
                    state_reg <= S_SUM_WR;
                end
                S_SUM_WR:
                begin
                    run_reg <= bk_sum;
                    if (idx_inc == klim)
                    begin
                        idx_reg   <= n_ext;
                        state_reg <= S_DST_A;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_SUM_RD;
                    end
                end
                // stable placement, walking order_a from the end
                S_DST_A:
                begin
                    state_reg <= S_DST_B;
                end
                S_DST_B:
                begin
                    pos_reg   <= oa_rdata;
                    state_reg <= S_DST_C;
                end
                S_DST_C:
                begin
                    cls_reg   <= ca_rdata;
                    state_reg <= S_DST_D;
                end
                S_DST_D:
                begin
                    idx_reg <= idx_dec;
                    if (idx_reg == IW'(1))
                    begin
                        state_reg <= first_reg ? S_HCHK : S_REN_0;
                    end
                    else
                    begin
                        state_reg <= S_DST_A;
                    end
                end
                S_HCHK:
                begin
                    idx_reg   <= '0;
                    first_reg <= 1'b0;
                    if (h_reg < HW'(n_reg))
                    begin
                        state_reg <= S_SHF_RD;
                    end
                    else
                    begin
                        sorted_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                // shift each position back by h
                S_SHF_RD:
                begin
                    state_reg <= S_SHF_WR;
                end
                S_SHF_WR:
                begin
                    if (idx_inc == n_ext)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_SHF_RD;
                    end
                end
                // renumber classes on (class[p], class[p+h]) pairs
                S_REN_0:
                begin
                    state_reg <= S_REN_1;
                end
                S_REN_1:
                begin
                    prev_reg  <= ob_rdata;
                    crun_reg  <= '0;
                    idx_reg   <= IW'(1);
                    state_reg <= S_REN_A;
                end
                S_REN_A:
                begin
                    state_reg <= S_REN_B;
                end
                S_REN_B:
                begin
                    cur_reg   <= ob_rdata;
                    state_reg <= S_REN_C;
                end
                S_REN_C:
                begin
                    x_reg     <= ca_rdata;
                    state_reg <= S_REN_D;
                end
                S_REN_D:
                begin
                    eq_reg    <= (x_reg == ca_rdata);
                    state_reg <= S_REN_E;
                end
                S_REN_E:
                begin
                    x_reg     <= ca_rdata;
                    state_reg <= S_REN_F;
                end
                S_REN_F:
                begin
                    crun_reg <= crun_new;
                    prev_reg <= cur_reg;
                    if (idx_inc == n_ext)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CPY_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_REN_A;
                    end
                end
                // new classes become current
                S_CPY_RD:
                begin
                    state_reg <= S_CPY_WR;
                end
                S_CPY_WR:
                begin
                    if (idx_inc == n_ext)
                    begin
                        h_reg     <= {h_reg[HW-2:0], 1'b0};
                        state_reg <= S_HCHK;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_CPY_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    csort_ram #(.DEPTH(MAX_LEN), .WIDTH(CHAR_W)) u_text (
        .clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
        .raddr(txt_raddr), .rdata(txt_rdata)
    );

    csort_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_order_a (
        .clk(clk), .we(oa_we), .waddr(oa_waddr), .wdata(oa_wdata),
        .raddr(oa_raddr), .rdata(oa_rdata)
    );

    csort_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_order_b (
        .clk(clk), .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
        .raddr(ob_raddr), .rdata(ob_rdata)
    );

    csort_ram #(.DEPTH(MAX_LEN), .WIDTH(CW)) u_class_a (
        .clk(clk), .we(ca_we), .waddr(ca_waddr), .wdata(ca_wdata),
        .raddr(ca_raddr), .rdata(ca_rdata)
    );

    csort_ram #(.DEPTH(MAX_LEN), .WIDTH(CW)) u_class_b (
        .clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(cb_wdata),
        .raddr(cb_raddr), .rdata(cb_rdata)
    );

    csort_ram #(.DEPTH(NB), .WIDTH(LW)) u_buckets (
        .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_rdata)
    );

endmodule

`default_nettype wire

@@ src/csort_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csort_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          req_type,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [csort_pkg::POS_W-1:0]    rsp_position,
    input wire logic [csort_pkg::STATUS_W-1:0] rsp_status
);
    import csort_pkg::*;

    logic last_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_type_reg <= REQ_LOAD;
        end
        else if (req_valid && req_ready)
        begin
            last_type_reg <= req_type;
        end
    end

    // a rejected read or an overflowing load carries no position
    a_err_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_position == '0))
        else $error("non-ok response with non-zero position");

    // overflow only answers a load
    a_ovf_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_OVERFLOW) |-> (last_type_reg == REQ_LOAD))
        else $error("overflow status on a read response");

    // an invalid rank only answers a read
    a_inv_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_INVALID) |-> (last_type_reg == REQ_READ))
        else $error("invalid status on a load response");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
                                    && $stable(rsp_status))
        else $error("stalled response changed");

endmodule

bind cyclic_shift_sorter csort_checker u_csort_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .req_type(req.req_type),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_position(rsp.position),
    .rsp_status(rsp.status)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import csort_pkg::*;

    localparam int STR_MAX    = 1024;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic [RANK_W-1:0] rank;
    } shift_req_t;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
    } shift_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    csort_req_if req ();
    csort_rsp_if rsp ();

    cyclic_shift_sorter #(.MAX_LEN(STR_MAX)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #5 clk = ~clk;

    // pending requests and the responses they are predicted to cause
    shift_req_t pending_q[$];
    shift_rsp_t expected_rsp_q[$];

    int errors = 0;
    int n_sorted = 0;
    int n_hits = 0;
    int n_overflow = 0;
    int n_rejected = 0;
    int cycles = 0;
    bit stim_done = 1'b0;

    // shadow copy of the sorter state
    logic [7:0] text_mem [STR_MAX];
    int unsigned ord_a [STR_MAX];
    int unsigned ord_b [STR_MAX];
    int unsigned cls_a [STR_MAX];
    int unsigned cls_b [STR_MAX];
    int unsigned bucket [STR_MAX];
    int unsigned text_len = 0;
    bit order_ready = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // stable counting sort of ord_a by class into ord_b
    function automatic void bucket_sort(input int unsigned n);
        int unsigned i;
        int unsigned p;
        for (i = 0; i < STR_MAX; i++)
            bucket[i] = 0;
        for (i = 0; i < n; i++)
            bucket[cls_a[ord_a[i]]]++;
        for (i = 1; i < STR_MAX; i++)
            bucket[i] += bucket[i-1];
        for (i = n; i > 0; i--)
        begin
            p = ord_a[i-1];
            bucket[cls_a[p]]--;
            ord_b[bucket[cls_a[p]]] = p;
        end
    endfunction

    // prefix doubling over all cyclic shifts, final order left in ord_b
    function automatic void sort_rotations(input int unsigned n);
        int unsigned i;
        int unsigned h;
        int unsigned cur;
        int unsigned prv;
        bit same;
        for (i = 0; i < n; i++)
        begin
            ord_a[i] = i;
            cls_a[i] = text_mem[i];
        end
        bucket_sort(n);
        for (h = 1; h < n; h <<= 1)
        begin
            for (i = 0; i < n; i++)
                ord_a[i] = (ord_b[i] + n - h) % n;
            bucket_sort(n);
            cls_b[ord_b[0]] = 0;
            for (i = 1; i < n; i++)
            begin
                cur = ord_b[i];
                prv = ord_b[i-1];
                same = (cls_a[cur] == cls_a[prv]) &&
                       (cls_a[(cur + h) % n] == cls_a[(prv + h) % n]);
                cls_b[cur] = cls_b[prv] + (same ? 0 : 1);
            end
            for (i = 0; i < n; i++)
                cls_a[i] = cls_b[i];
        end
    endfunction

    // predicted response of one accepted request
    function automatic shift_rsp_t predict_rotation_rank(input shift_req_t r);
        shift_rsp_t o;
        o.position = '0;
        o.status   = ST_OK;
        if (r.req_type == REQ_LOAD)
        begin
            if (order_ready)
            begin
                order_ready = 1'b0;
                text_len = 0;
            end
            if (text_len < STR_MAX)
            begin
                text_mem[text_len] = r.char_code;
                text_len++;
            end
            else
            begin
                o.status = ST_OVERFLOW;
                n_overflow++;
            end
            if (r.is_last && text_len > 0)
            begin
                sort_rotations(text_len);
                order_ready = 1'b1;
                n_sorted++;
            end
        end
        else if (!order_ready || r.rank >= text_len)
        begin
            o.status = ST_INVALID;
            n_rejected++;
        end
        else
        begin
            o.position = POS_W'(ord_b[r.rank]);
            n_hits++;
        end
        return o;
    endfunction

    function automatic shift_req_t mk_load(input int c, input bit last);
        shift_req_t r;
        r.req_type  = REQ_LOAD;
        r.char_code = CHAR_W'(c);
        r.is_last   = last;
        r.rank      = RANK_W'($urandom);
        return r;
    endfunction

    function automatic shift_req_t mk_read(input int k);
        shift_req_t r;
        r.req_type  = REQ_READ;
        r.char_code = CHAR_W'($urandom);
        r.is_last   = 1'($urandom);
        r.rank      = RANK_W'(k);
        return r;
    endfunction

    // a string of len characters, alphabet narrowed at times to force class ties
    task automatic push_string(input int len, input bit close);
        int alpha;
        int c;
        alpha = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
        begin
            c = (alpha == 256) ? $urandom_range(0, 255) : $urandom_range(0, alpha - 1);
            if (alpha != 256 && $urandom_range(0, 1))
                c = 255 - c;
            pending_q.push_back(mk_load(c, close && (i == len - 1)));
        end
    endtask

    task automatic push_reads(input int n, input int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                pending_q.push_back(mk_read($urandom_range(n, 1023)));
            else
                pending_q.push_back(mk_read($urandom_range(0, n - 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus: directed corner cases, then random strings and reads
    // ------------------------------------------------------------------
    initial
    begin
        int len;
        bit big_done;
        big_done = 1'b0;

        // read with nothing sorted yet
        pending_q.push_back(mk_read(0));
        // single character string: only rank 0 is valid
        pending_q.push_back(mk_load(0, 1'b1));
        pending_q.push_back(mk_read(0));
        pending_q.push_back(mk_read(1));
        pending_q.push_back(mk_read(1023));
        // extreme bytes, checks the unsigned compare
        pending_q.push_back(mk_load(255, 1'b0));
        pending_q.push_back(mk_read(0));
        pending_q.push_back(mk_load(0, 1'b0));
        pending_q.push_back(mk_load(128, 1'b0));
        pending_q.push_back(mk_load(127, 1'b1));
        for (int k = 0; k < 5; k++)
            pending_q.push_back(mk_read(k));
        // all equal characters, every class ties
        for (int k = 0; k < 5; k++)
            pending_q.push_back(mk_load(8'h55, k == 4));
        pending_q.push_back(mk_read(0));
        pending_q.push_back(mk_read(4));
        pending_q.push_back(mk_read(5));

        while (pending_q.size() < 1500)
        begin
            if (!big_done && pending_q.size() > 400)
            begin
                // full store, then two overflowing loads, the second closing the string
                for (int k = 0; k < STR_MAX; k++)
                    pending_q.push_back(mk_load($urandom_range(0, 3), 1'b0));
                pending_q.push_back(mk_load($urandom_range(0, 255), 1'b0));
                pending_q.push_back(mk_load($urandom_range(0, 255), 1'b1));
                push_reads(STR_MAX, 40);
                big_done = 1'b1;
            end
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            if ($urandom_range(0, 9) == 0)
            begin
                // open string interrupted by a read, then closed
                push_string(len, 1'b0);
                pending_q.push_back(mk_read($urandom_range(0, 1023)));
                push_string(1, 1'b1);
                len++;
            end
            else
            begin
                push_string(len, 1'b1);
            end
            push_reads(len, $urandom_range(1, len + 4));
        end
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // driver: bursts of transactions with random gaps, changes on falling edge
    // ------------------------------------------------------------------
    bit req_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;

    initial
    begin
        req.valid     = 1'b0;
        req.req_type  = REQ_LOAD;
        req.char_code = '0;
        req.is_last   = 1'b0;
        req.rank      = '0;
        rsp.ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!req.valid || req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                shift_req_t nxt;
                nxt = pending_q.pop_front();
                req.valid     <= 1'b1;
                req.req_type  <= nxt.req_type;
                req.char_code <= nxt.char_code;
                req.is_last   <= nxt.is_last;
                req.rank      <= nxt.rank;
                if (burst_left > 1)
                    burst_left <= burst_left - 1;
                else
                begin
                    // end of burst: sometimes back to back, sometimes a pause
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // receiver backpressure: the pattern changes every so often
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (stall_phase == 0)
                stall_mode <= $urandom_range(0, 3);
            stall_phase <= (stall_phase + 1) % 97;
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 1) == 1);
                2: rsp.ready <= (stall_phase % 3 == 0);
                default: rsp.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on accepted requests, checks accepted responses
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        shift_req_t seen;
        shift_rsp_t got;
        shift_rsp_t want;
        cycles <= cycles + 1;
        req_taken <= 1'b0;
        if (rst_n && req.valid && req.ready)
        begin
            seen.req_type  = req.req_type;
            seen.char_code = req.char_code;
            seen.is_last   = req.is_last;
            seen.rank      = req.rank;
            expected_rsp_q.push_back(predict_rotation_rank(seen));
            req_taken <= 1'b1;
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.position = rsp.position;
            got.status   = rsp.status;
            if (expected_rsp_q.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                want = expected_rsp_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.position !== want.position)
                    report_mismatch("position", got.position, want.position);
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // end of run: all sent, all answered, then a short drain
    initial
    begin
        wait (stim_done);
        wait (pending_q.size() == 0 && !req.valid && expected_rsp_q.size() == 0);
        repeat (50) @(posedge clk);
        if (expected_rsp_q.size() != 0)
            report_mismatch("responses still outstanding", 0, expected_rsp_q.size());
        $display("covered %0d sorted strings, %0d good reads, %0d rejected reads, %0d overflows",
                 n_sorted, n_hits, n_rejected, n_overflow);
        $display("%0d cycles, %0d mismatches", cycles, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
